/* src/pgi_pkg.sv */
`timescale 1ns / 1ps

package pgi_pkg;

	// Detector state codes as they arrive on the input item.
	typedef enum logic [1:0] {
		DET_OTHER   = 2'd0,
		DET_COVERED = 2'd1,
		DET_CALIB   = 2'd2,
		DET_FAULT   = 2'd3
	} det_state_t;

	// Indicator mode codes on the result item.
	typedef enum logic [2:0] {
		MODE_IDLE   = 3'd0,
		MODE_FAULT  = 3'd1,
		MODE_CALIB  = 3'd2,
		MODE_FIRED  = 3'd3,
		MODE_COVER  = 3'd4
	} glow_mode_t;

	// Configuration register indexes.
	typedef enum logic [2:0] {
		REG_REACT   = 3'd0,
		REG_COVER   = 3'd1,
		REG_UNCOVER = 3'd2,
		REG_HOLD    = 3'd3,
		REG_FLOOR   = 3'd4,
		REG_CEILING = 3'd5,
		REG_PERIOD  = 3'd6,
		REG_PULSE   = 3'd7
	} cfg_reg_t;

	localparam logic [16:0] Q15_ONE     = 17'd32768;
	localparam logic [15:0] FAULT_LEVEL = 16'd26214;
	localparam logic [63:0] Q30_ONE     = 64'd1073741824;
	localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

	localparam logic [15:0] RST_REACT   = 16'd15892;
	localparam logic [15:0] RST_COVER   = 16'd11469;
	localparam logic [15:0] RST_UNCOVER = 16'd13926;
	localparam logic [15:0] RST_HOLD    = 16'd600;
	localparam logic [15:0] RST_FLOOR   = 16'd4915;
	localparam logic [15:0] RST_CEILING = 16'd11469;
	localparam logic [15:0] RST_PERIOD  = 16'd4000;
	localparam logic [15:0] RST_PULSE   = 16'd400;

	// Cosine of a quarter-turn fraction (Q30) by a nested Taylor series, in Q30.
	function automatic logic [63:0] quarter_cos(input logic [63:0] f);
		logic [63:0] a;
		logic [63:0] a2;
		logic [63:0] x;
		logic [63:0] q;
		logic signed [63:0] t;
		a = (f * HALF_PI_Q30) >> 30;
		a2 = (a * a) >> 30;
		t = signed'(Q30_ONE);
		for (int i = 0; i < 5; i++) begin
			x = (a2 * unsigned'(t)) >> 30;
			case (i)
				0: q = x / 90;
				1: q = x / 56;
				2: q = x / 30;
				3: q = x / 12;
				default: q = x / 2;
			endcase
			t = signed'(Q30_ONE) - signed'(q);
			if (t < 0) begin
				t = 0;
			end
		end
		if (t > signed'(Q30_ONE)) begin
			t = signed'(Q30_ONE);
		end
		return unsigned'(t);
	endfunction

	// Raised-cosine level in Q1.15 for a phase given as a 32-bit turn fraction.
	function automatic logic [15:0] breath_entry(input logic [63:0] p);
		logic [63:0] f;
		logic signed [63:0] c;
		logic [63:0] r;
		f = {34'd0, p[29:0]};
		case (p[31:30])
			2'd0: c = signed'(quarter_cos(f));
			2'd1: c = -signed'(quarter_cos(Q30_ONE - f));
			2'd2: c = -signed'(quarter_cos(f));
			default: c = signed'(quarter_cos(Q30_ONE - f));
		endcase
		r = (unsigned'(signed'(Q30_ONE) - c) + 64'd32768) >> 16;
		return r[15:0];
	endfunction

endpackage

/* src/pgi_div.sv */
`timescale 1ns / 1ps

// Pipelined restoring divider: one quotient bit per stage. The initial
// remainder must lie below the divisor; the numerator bits are shifted in
// from the top. A side word travels along with each item.
module pgi_div #(
	parameter int DEN_W  = 16,
	parameter int NUM_W  = 32,
	parameter int SIDE_W = 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_valid,
	input  logic [DEN_W-1:0]  den,
	input  logic [DEN_W-1:0]  rem_init,
	input  logic [NUM_W-1:0]  num,
	input  logic [SIDE_W-1:0] side_in,
	output logic              out_valid,
	output logic [NUM_W-1:0]  quo,
	output logic [DEN_W-1:0]  rem,
	output logic [SIDE_W-1:0] side_out
);

	logic              vld_s  [NUM_W+1];
	logic [DEN_W-1:0]  rem_s  [NUM_W+1];
	logic [NUM_W-1:0]  num_s  [NUM_W+1];
	logic [NUM_W-1:0]  quo_s  [NUM_W+1];
	logic [SIDE_W-1:0] side_s [NUM_W+1];

	assign vld_s[0]  = in_valid;
	assign rem_s[0]  = rem_init;
	assign num_s[0]  = num;
	assign quo_s[0]  = '0;
	assign side_s[0] = side_in;

	for (genvar j = 0; j < NUM_W; j++) begin : g_step
		logic [DEN_W:0] trial;
		logic           take;

		// Trial subtraction of the divisor from the shifted remainder.
		assign trial = {rem_s[j], num_s[j][NUM_W-1]};
		assign take  = trial >= {1'b0, den};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[j+1] <= 1'b0;
			end else if (en) begin
				vld_s[j+1] <= vld_s[j];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[j+1]  <= take ? DEN_W'(trial - {1'b0, den}) : trial[DEN_W-1:0];
				num_s[j+1]  <= {num_s[j][NUM_W-2:0], 1'b0};
				quo_s[j+1]  <= {quo_s[j][NUM_W-2:0], take};
				side_s[j+1] <= side_s[j];
			end
		end
	end

	assign out_valid = vld_s[NUM_W];
	assign quo       = quo_s[NUM_W];
	assign rem       = rem_s[NUM_W];
	assign side_out  = side_s[NUM_W];

endmodule

/* src/proximity_glow_indicator.sv */
`timescale 1ns / 1ps

// Proximity glow indicator. Takes one item per clock while the pipeline is
// not stalled and returns one result per item, in order. Each item passes
// the capture and elapsed-time registers, then a chain of bit-serial divider
// stages: the breath phase (TIME_BITS stages), the table index (16 + clog2
// depth stages) and the pulse, progress and depth fractions (15 stages each),
// followed by the table read, the blend multiply and the final clamp. A held
// result stalls the whole pipeline, so in_stall follows out_stall while a
// result is waiting.
// Configuration writes are taken in any cycle with cfg_ready held high, but
// must only be issued while no items are in flight.
module proximity_glow_indicator import pgi_pkg::*; #(
	parameter int BREATH_TABLE_DEPTH = 256,
	parameter int TIME_BITS          = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [2:0]           cfg_index,
	input  logic [15:0]          cfg_data,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [1:0]           detector_state,
	input  logic                 gesture_seen,
	input  logic [TIME_BITS-1:0] now_ms,
	input  logic [TIME_BITS-1:0] last_gesture_ms,
	input  logic [TIME_BITS-1:0] cover_start_ms,
	input  logic [15:0]          light_ratio,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [2:0]           glow_mode,
	output logic [15:0]          intensity,
	output logic [15:0]          progress,
	output logic [15:0]          pulse
);

	localparam int AW = $clog2(BREATH_TABLE_DEPTH);
	localparam int KW = 16 + AW;

	typedef struct packed {
		det_state_t    state;
		logic          pulse_full;
		logic          pulse_zero;
		logic [15:0]   pulse_x;
		logic          prog_full;
		logic          prog_zero;
		logic [15:0]   prog_x;
		logic          depth_full;
		logic          depth_zero;
		logic [15:0]   depth_x;
		logic [AW-1:0] k;
		logic [15:0]   pulse_v;
		logic [15:0]   prog_v;
	} side_t;

	localparam int SIDE_W = $bits(side_t);

	// Configuration registers.
	logic [15:0] react_q, cover_q, uncover_q, hold_q;
	logic [15:0] floor_q, ceiling_q, period_q, pulse_len_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			react_q     <= RST_REACT;
			cover_q     <= RST_COVER;
			uncover_q   <= RST_UNCOVER;
			hold_q      <= RST_HOLD;
			floor_q     <= RST_FLOOR;
			ceiling_q   <= RST_CEILING;
			period_q    <= RST_PERIOD;
			pulse_len_q <= RST_PULSE;
		end else if (cfg_valid) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_REACT:   react_q     <= cfg_data;
				REG_COVER:   cover_q     <= cfg_data;
				REG_UNCOVER: uncover_q   <= cfg_data;
				REG_HOLD:    hold_q      <= cfg_data;
				REG_FLOOR:   floor_q     <= cfg_data;
				REG_CEILING: ceiling_q   <= cfg_data;
				REG_PERIOD:  period_q    <= cfg_data;
				REG_PULSE:   pulse_len_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Derived settings: zero lengths act as one, and the reaction start
	// falls back to the uncover threshold.
	logic [15:0] period_eff, len_eff, start_w, band_w;
	logic        band_pos;

	assign period_eff = (period_q == 16'd0) ? 16'd1 : period_q;
	assign len_eff    = (pulse_len_q == 16'd0) ? 16'd1 : pulse_len_q;
	assign start_w    = (react_q <= cover_q) ? uncover_q : react_q;
	assign band_pos   = start_w > cover_q;
	assign band_w     = start_w - cover_q;

	// Raised-cosine table, worked out at elaboration.
	logic [15:0] breath_rom [BREATH_TABLE_DEPTH];

	for (genvar gk = 0; gk < BREATH_TABLE_DEPTH; gk++) begin : g_rom
		localparam logic [63:0] PHASE = (64'(gk) << 32) / BREATH_TABLE_DEPTH;
		assign breath_rom[gk] = breath_entry(PHASE);
	end

	// The whole pipeline moves unless a finished result is held.
	logic en;
	logic vld_s5;

	assign en       = !vld_s5 || !out_stall;
	assign in_stall = !en;

	// Stage 1: capture the item.
	logic                 vld_s1, seen_s1;
	det_state_t           state_s1;
	logic [TIME_BITS-1:0] now_s1, last_s1, cstart_s1;
	logic [15:0]          ratio_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			state_s1  <= det_state_t'(detector_state);
			seen_s1   <= gesture_seen;
			now_s1    <= now_ms;
			last_s1   <= last_gesture_ms;
			cstart_s1 <= cover_start_ms;
			ratio_s1  <= light_ratio;
		end
	end

	// Stage 2: elapsed times and the special cases of each fraction.
	logic [TIME_BITS-1:0] gdiff, cdiff, gd, cd;
	logic                 prog_on;
	logic [15:0]          depth_n;
	side_t                side_c2;

	assign gdiff   = now_s1 - last_s1;
	assign cdiff   = now_s1 - cstart_s1;
	assign gd      = gdiff[TIME_BITS-1] ? '0 : gdiff;
	assign cd      = cdiff[TIME_BITS-1] ? '0 : cdiff;
	assign prog_on = (state_s1 == DET_COVERED) && (hold_q != 16'd0);
	assign depth_n = start_w - ratio_s1;

	always_comb begin
		side_c2            = '0;
		side_c2.state      = state_s1;
		side_c2.pulse_full = seen_s1 && (gd == '0);
		side_c2.pulse_zero = !seen_s1 || (gd >= TIME_BITS'(len_eff));
		side_c2.pulse_x    = len_eff - gd[15:0];
		side_c2.prog_zero  = !prog_on;
		side_c2.prog_full  = prog_on && (cd >= TIME_BITS'(hold_q));
		side_c2.prog_x     = cd[15:0];
		side_c2.depth_x    = depth_n;
		if (!band_pos) begin
			side_c2.depth_full = ratio_s1 < start_w;
			side_c2.depth_zero = !(ratio_s1 < start_w);
		end else begin
			side_c2.depth_zero = ratio_s1 >= start_w;
			side_c2.depth_full = (ratio_s1 < start_w) && (depth_n >= band_w);
		end
	end

	logic                 vld_s2;
	side_t                side_s2;
	logic [TIME_BITS-1:0] now_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s2 <= side_c2;
			now_s2  <= now_s1;
		end
	end

	// Breath phase: the time modulo the period.
	logic              mod_vld;
	logic [15:0]       phase;
	logic [SIDE_W-1:0] mod_side;

	pgi_div #(.DEN_W(16), .NUM_W(TIME_BITS), .SIDE_W(SIDE_W)) u_mod (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (vld_s2),
		.den      (period_eff),
		.rem_init (16'd0),
		.num      (now_s2),
		.side_in  (side_s2),
		.out_valid(mod_vld),
		.quo      (),
		.rem      (phase),
		.side_out (mod_side)
	);

	// Table index: phase scaled by the table depth over the period.
	logic              k_vld;
	logic [KW-1:0]     k_num, k_quo;
	logic [SIDE_W-1:0] k_side;

	assign k_num = KW'(phase) * KW'(BREATH_TABLE_DEPTH);

	pgi_div #(.DEN_W(16), .NUM_W(KW), .SIDE_W(SIDE_W)) u_kdiv (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (mod_vld),
		.den      (period_eff),
		.rem_init (16'd0),
		.num      (k_num),
		.side_in  (mod_side),
		.out_valid(k_vld),
		.quo      (k_quo),
		.rem      (),
		.side_out (k_side)
	);

	// Pulse fraction.
	side_t             side_p;
	logic              p_vld;
	logic [14:0]       p_quo;
	logic [SIDE_W-1:0] p_side;

	always_comb begin
		side_p   = side_t'(k_side);
		side_p.k = k_quo[AW-1:0];
	end

	pgi_div #(.DEN_W(16), .NUM_W(15), .SIDE_W(SIDE_W)) u_pdiv (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (k_vld),
		.den      (len_eff),
		.rem_init (side_p.pulse_x),
		.num      (15'd0),
		.side_in  (side_p),
		.out_valid(p_vld),
		.quo      (p_quo),
		.rem      (),
		.side_out (p_side)
	);

	// Progress fraction.
	side_t             side_g;
	logic              g_vld;
	logic [14:0]       g_quo;
	logic [SIDE_W-1:0] g_side;

	always_comb begin
		side_g = side_t'(p_side);
		if (side_g.pulse_full) begin
			side_g.pulse_v = Q15_ONE[15:0];
		end else if (side_g.pulse_zero) begin
			side_g.pulse_v = 16'd0;
		end else begin
			side_g.pulse_v = {1'b0, p_quo};
		end
	end

	pgi_div #(.DEN_W(16), .NUM_W(15), .SIDE_W(SIDE_W)) u_gdiv (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (p_vld),
		.den      (hold_q),
		.rem_init (side_g.prog_x),
		.num      (15'd0),
		.side_in  (side_g),
		.out_valid(g_vld),
		.quo      (g_quo),
		.rem      (),
		.side_out (g_side)
	);

	// Cover depth fraction.
	side_t             side_d;
	logic              d_vld;
	logic [14:0]       d_quo;
	logic [SIDE_W-1:0] d_side;

	always_comb begin
		side_d = side_t'(g_side);
		if (side_d.prog_zero) begin
			side_d.prog_v = 16'd0;
		end else if (side_d.prog_full) begin
			side_d.prog_v = Q15_ONE[15:0];
		end else begin
			side_d.prog_v = {1'b0, g_quo};
		end
	end

	pgi_div #(.DEN_W(16), .NUM_W(15), .SIDE_W(SIDE_W)) u_ddiv (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (g_vld),
		.den      (band_w),
		.rem_init (side_d.depth_x),
		.num      (15'd0),
		.side_in  (side_d),
		.out_valid(d_vld),
		.quo      (d_quo),
		.rem      (),
		.side_out (d_side)
	);

	// Stage 3: depth value and the breath table read.
	side_t       side_c3;
	logic [15:0] depth_c3;

	assign side_c3 = side_t'(d_side);

	always_comb begin
		if (side_c3.depth_full) begin
			depth_c3 = Q15_ONE[15:0];
		end else if (side_c3.depth_zero) begin
			depth_c3 = 16'd0;
		end else begin
			depth_c3 = {1'b0, d_quo};
		end
	end

	logic        vld_s3;
	det_state_t  state_s3;
	logic [15:0] pulse_s3, prog_s3, depth_s3, breath_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s3 <= d_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			state_s3  <= side_c3.state;
			pulse_s3  <= side_c3.pulse_v;
			prog_s3   <= side_c3.prog_v;
			depth_s3  <= depth_c3;
			breath_s3 <= breath_rom[side_c3.k];
		end
	end

	// Stage 4: blend magnitude product, truncated toward zero.
	logic        dz, neg_c4;
	logic [15:0] base_c4, mag_c4, frac_c4;
	logic [31:0] prod_c4;
	logic [16:0] hi_gap;

	assign dz     = depth_s3 == 16'd0;
	assign hi_gap = Q15_ONE - {1'b0, ceiling_q};

	always_comb begin
		if (dz) begin
			base_c4 = floor_q;
			neg_c4  = ceiling_q < floor_q;
			mag_c4  = neg_c4 ? (floor_q - ceiling_q) : (ceiling_q - floor_q);
			frac_c4 = breath_s3;
		end else begin
			base_c4 = ceiling_q;
			neg_c4  = {1'b0, ceiling_q} > Q15_ONE;
			mag_c4  = neg_c4 ? 16'(({1'b0, ceiling_q} - Q15_ONE)) : hi_gap[15:0];
			frac_c4 = depth_s3;
		end
	end

	assign prod_c4 = mag_c4 * frac_c4;

	logic        vld_s4, neg_s4;
	det_state_t  state_s4;
	logic [15:0] pulse_s4, prog_s4, base_s4;
	logic [16:0] prod_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
		end else if (en) begin
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			state_s4 <= state_s3;
			pulse_s4 <= pulse_s3;
			prog_s4  <= prog_s3;
			base_s4  <= base_c4;
			neg_s4   <= neg_c4;
			prod_s4  <= prod_c4[31:15];
		end
	end

	// Stage 5: add, clamp and apply the mode priority.
	logic signed [18:0] sum_c5;
	logic [15:0]        level_c5, int_c5, prog_c5, pulse_c5;
	glow_mode_t         mode_c5;

	assign sum_c5 = neg_s4 ? ($signed({3'b000, base_s4}) - $signed({2'b00, prod_s4}))
	                       : ($signed({3'b000, base_s4}) + $signed({2'b00, prod_s4}));

	always_comb begin
		if (sum_c5 < 0) begin
			level_c5 = 16'd0;
		end else if (sum_c5 > $signed({2'b00, Q15_ONE})) begin
			level_c5 = Q15_ONE[15:0];
		end else begin
			level_c5 = sum_c5[15:0];
		end
	end

	always_comb begin
		int_c5   = level_c5;
		prog_c5  = prog_s4;
		pulse_c5 = pulse_s4;
		if (state_s4 == DET_FAULT) begin
			mode_c5  = MODE_FAULT;
			int_c5   = FAULT_LEVEL;
			prog_c5  = 16'd0;
			pulse_c5 = 16'd0;
		end else if (state_s4 == DET_CALIB) begin
			mode_c5  = MODE_CALIB;
			prog_c5  = 16'd0;
			pulse_c5 = 16'd0;
		end else if (pulse_s4 != 16'd0) begin
			mode_c5 = MODE_FIRED;
		end else if (state_s4 == DET_COVERED) begin
			mode_c5 = MODE_COVER;
		end else begin
			mode_c5 = MODE_IDLE;
		end
	end

	glow_mode_t  mode_s5;
	logic [15:0] int_s5, prog_s5, pulse_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s5 <= 1'b0;
		end else if (en) begin
			vld_s5 <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mode_s5  <= mode_c5;
			int_s5   <= int_c5;
			prog_s5  <= prog_c5;
			pulse_s5 <= pulse_c5;
		end
	end

	assign out_valid = vld_s5;
	assign glow_mode = mode_s5;
	assign intensity = int_s5;
	assign progress  = prog_s5;
	assign pulse     = pulse_s5;

endmodule
